### sv/sem_pkg.sv
// ----------------------------------------------------------------------------
// Sobel edge magnitude package
// Shared widths, register indexes, controller states and the command and
// status groups that pass between controller and datapath.
// ----------------------------------------------------------------------------
package sem_pkg;

   localparam int MAX_WIDTH  = 8192;
   localparam int MAX_HEIGHT = 8192;

   localparam int DIM_W   = 14;
   localparam int PIX_W   = 8;
   localparam int MAG_W   = 8;
   localparam int POS_W   = 13;
   localparam int COL_W   = $clog2(MAX_WIDTH);
   localparam int ROW_W   = $clog2(MAX_HEIGHT);
   localparam int GRAD_W  = 11;
   localparam int ABS_W   = 10;
   localparam int SQ_W    = 2 * ABS_W;
   localparam int SUM_W   = SQ_W + 1;
   localparam int REM_W   = 17;
   localparam int BIT_W   = 16;
   localparam int STEP_W  = 3;
   localparam int CSR_IDX_W = 2;

   localparam logic [DIM_W-1:0] DIM_MIN          = DIM_W'(3);
   localparam logic [DIM_W-1:0] WIDTH_MAX        = DIM_W'(MAX_WIDTH);
   localparam logic [DIM_W-1:0] HEIGHT_MAX       = DIM_W'(MAX_HEIGHT);
   localparam logic [DIM_W-1:0] WIDTH_RESET      = DIM_W'(7680);
   localparam logic [DIM_W-1:0] HEIGHT_RESET     = DIM_W'(4320);
   localparam logic [MAG_W-1:0] MAG_LIMIT        = 8'd255;
   localparam logic [BIT_W-1:0] ROOT_BIT_START   = 16'h4000;
   localparam logic [STEP_W-1:0] ROOT_STEP_LAST  = 3'd7;

   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CALC,
      ST_SQUARE,
      ST_SUM,
      ST_ROOT,
      ST_HOLD
   } sem_state_type;

   typedef struct packed {
      logic capture;
      logic calc;
      logic square;
      logic sum;
      logic root_step;
      logic load_out;
   } sem_cmd_type;

   typedef struct packed {
      logic interior;
      logic root_last;
      logic out_free;
   } sem_status_type;

endpackage

### sv/sobel_edge_magnitude.sv
// ----------------------------------------------------------------------------
// Sobel edge magnitude
// Streams 8-bit grey pixels in raster order and returns the saturated
// Sobel gradient magnitude for every interior pixel of the frame.
// ----------------------------------------------------------------------------
// Usage:
//   req_valid/req_ready/req_pixel take one pixel word per handshake in raster
//   order. rsp_* carry one result word per interior centre pixel with its
//   row, column and a frame_last mark; border pixels give no word.
//   csr_we writes image_width (index 0) or image_height (index 1) and
//   restarts the frame; write only while the block is idle.
// Timing:
//   A border pixel returns to idle after the window update. An interior pixel
//   passes through squaring, summing and the eight-step square root, which
//   resolves one result bit per cycle; its word is loaded once the output
//   register is free, and the next pixel is taken in the cycle after that.
// Reset: clears the counters, the window and the result valid flag and loads
//   the default 7680 x 4320 frame size. Line stores are not cleared.
// Stall: a held result word stays in the output register; the block takes
//   the next pixel meanwhile and waits only when a second word is ready.
// ----------------------------------------------------------------------------
module sobel_edge_magnitude import sem_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [PIX_W-1:0]     req_pixel,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [MAG_W-1:0]     rsp_magnitude,
   output logic [POS_W-1:0]     rsp_center_row,
   output logic [POS_W-1:0]     rsp_center_col,
   output logic                 rsp_frame_last,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DIM_W-1:0]     csr_wdata
);

   sem_cmd_type    cmd;
   sem_status_type status;

   // sequence control
   sem_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // window, arithmetic and result register
   sem_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .req_pixel      (req_pixel),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .cmd            (cmd),
      .status         (status),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_magnitude  (rsp_magnitude),
      .rsp_center_row (rsp_center_row),
      .rsp_center_col (rsp_center_col),
      .rsp_frame_last (rsp_frame_last)
   );

endmodule

### sv/sem_ctrl.sv
// ----------------------------------------------------------------------------
// Sobel edge magnitude controller
// Sequences one pixel word at a time through window update and, for interior
// pixels, squaring, summing, the iterative square root and the output load.
// ----------------------------------------------------------------------------
module sem_ctrl import sem_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  sem_status_type status,
   output sem_cmd_type    cmd
);

   sem_state_type state_ff, state_in;

   // hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_CALC;
         end
         ST_CALC: begin
            state_in = status.interior ? ST_SQUARE : ST_IDLE;
         end
         ST_SQUARE: state_in = ST_SUM;
         ST_SUM:    state_in = ST_ROOT;
         ST_ROOT: begin
            if (status.root_last) state_in = ST_HOLD;
         end
         ST_HOLD: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   // drive commands
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         ST_CALC:   cmd.calc      = 1'b1;
         ST_SQUARE: cmd.square    = 1'b1;
         ST_SUM:    cmd.sum       = 1'b1;
         ST_ROOT:   cmd.root_step = 1'b1;
         ST_HOLD:   cmd.load_out  = status.out_free;
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

### sv/sem_datapath.sv
// ----------------------------------------------------------------------------
// Sobel edge magnitude datapath
// Line stores, 3x3 window, position counters, gradient arithmetic, the
// digit-by-digit square root and the result register.
// ----------------------------------------------------------------------------
module sem_datapath import sem_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [PIX_W-1:0]     req_pixel,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DIM_W-1:0]     csr_wdata,
   input  sem_cmd_type          cmd,
   output sem_status_type       status,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [MAG_W-1:0]     rsp_magnitude,
   output logic [POS_W-1:0]     rsp_center_row,
   output logic [POS_W-1:0]     rsp_center_col,
   output logic                 rsp_frame_last
);

   logic [PIX_W-1:0] upper_mem  [MAX_WIDTH];
   logic [PIX_W-1:0] middle_mem [MAX_WIDTH];

   logic [DIM_W-1:0] width_ff, height_ff;
   logic [COL_W-1:0] col_ff;
   logic [ROW_W-1:0] row_ff;
   logic [PIX_W-1:0] pix_ff, upper_rd_ff, middle_rd_ff;
   logic [PIX_W-1:0] win_ff [6];
   logic signed [GRAD_W-1:0] gx_ff, gy_ff;
   logic [SQ_W-1:0]   sqx_ff, sqy_ff;
   logic              sat_ff;
   logic [REM_W-1:0]  rem_ff, root_ff;
   logic [BIT_W-1:0]  bit_ff;
   logic [STEP_W-1:0] step_ff;
   logic [POS_W-1:0]  res_row_ff, res_col_ff;
   logic              res_last_ff;
   logic              rsp_valid_ff;
   logic [MAG_W-1:0]  rsp_mag_ff;
   logic [POS_W-1:0]  rsp_row_ff, rsp_col_ff;
   logic              rsp_last_ff;

   logic [DIM_W-1:0] w_eff, h_eff, w_last, h_last;
   logic             col_end, row_end;
   logic signed [GRAD_W-1:0] n0s, n1s, n2s, a0s, a1s, a2s, b0s, b2s;
   logic signed [GRAD_W-1:0] gx_in, gy_in;
   logic [ABS_W-1:0] gx_abs, gy_abs;
   logic [SUM_W-1:0] sum_in;
   logic [REM_W-1:0] trial;

   // clamp frame size
   always_comb begin
      priority if (width_ff < DIM_MIN) w_eff = DIM_MIN;
      else if (width_ff > WIDTH_MAX)   w_eff = WIDTH_MAX;
      else                             w_eff = width_ff;
      priority if (height_ff < DIM_MIN) h_eff = DIM_MIN;
      else if (height_ff > HEIGHT_MAX)  h_eff = HEIGHT_MAX;
      else                              h_eff = height_ff;
      w_last  = w_eff - DIM_W'(1);
      h_last  = h_eff - DIM_W'(1);
      col_end = (DIM_W'(col_ff) == w_last);
      row_end = (DIM_W'(row_ff) == h_last);
   end

   assign status.interior  = (row_ff >= ROW_W'(2)) && (col_ff >= COL_W'(2));
   assign status.root_last = (step_ff == ROOT_STEP_LAST);
   assign status.out_free  = !rsp_valid_ff || rsp_ready;

   // configuration and position counters
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
         col_ff    <= '0;
         row_ff    <= '0;
      end else if (csr_we &&
                   (csr_index == REG_IMAGE_WIDTH || csr_index == REG_IMAGE_HEIGHT)) begin
         if (csr_index == REG_IMAGE_WIDTH) width_ff <= csr_wdata;
         else                              height_ff <= csr_wdata;
         col_ff <= '0;
         row_ff <= '0;
      end else if (cmd.calc) begin
         if (col_end) begin
            col_ff <= '0;
            row_ff <= row_end ? '0 : row_ff + ROW_W'(1);
         end else begin
            col_ff <= col_ff + COL_W'(1);
         end
      end
   end

   // line stores: read on capture, write back during calc
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         upper_rd_ff  <= upper_mem[col_ff];
         middle_rd_ff <= middle_mem[col_ff];
      end
      if (cmd.calc) begin
         upper_mem[col_ff]  <= middle_rd_ff;
         middle_mem[col_ff] <= pix_ff;
      end
   end

   // gradients
   always_comb begin
      n0s = $signed({3'b000, upper_rd_ff});
      n1s = $signed({3'b000, middle_rd_ff});
      n2s = $signed({3'b000, pix_ff});
      a0s = $signed({3'b000, win_ff[0]});
      a1s = $signed({3'b000, win_ff[1]});
      a2s = $signed({3'b000, win_ff[2]});
      b0s = $signed({3'b000, win_ff[3]});
      b2s = $signed({3'b000, win_ff[5]});
      gx_in = (n0s - a0s) + ((n1s - a1s) <<< 1) + (n2s - a2s);
      gy_in = (a2s + (b2s <<< 1) + n2s) - (a0s + (b0s <<< 1) + n0s);
      gx_abs = gx_ff[GRAD_W-1] ? ABS_W'(-gx_ff) : ABS_W'(gx_ff);
      gy_abs = gy_ff[GRAD_W-1] ? ABS_W'(-gy_ff) : ABS_W'(gy_ff);
      sum_in = SUM_W'(sqx_ff) + SUM_W'(sqy_ff);
      trial  = root_ff + REM_W'(bit_ff);
   end

   // capture pixel, advance window, square and sum
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) win_ff[i] <= '0;
      end else if (cmd.calc) begin
         win_ff[0] <= win_ff[3];
         win_ff[1] <= win_ff[4];
         win_ff[2] <= win_ff[5];
         win_ff[3] <= upper_rd_ff;
         win_ff[4] <= middle_rd_ff;
         win_ff[5] <= pix_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) pix_ff <= req_pixel;
      if (cmd.calc) begin
         gx_ff       <= gx_in;
         gy_ff       <= gy_in;
         res_row_ff  <= POS_W'(row_ff - ROW_W'(1));
         res_col_ff  <= POS_W'(col_ff - COL_W'(1));
         res_last_ff <= row_end && col_end;
      end
      if (cmd.square) begin
         sqx_ff <= gx_abs * gx_abs;
         sqy_ff <= gy_abs * gy_abs;
      end
   end

   // square root, one result bit per step
   always_ff @(posedge clock) begin
      if (cmd.sum) begin
         sat_ff  <= |sum_in[SUM_W-1:16];
         rem_ff  <= REM_W'(sum_in[15:0]);
         root_ff <= '0;
         bit_ff  <= ROOT_BIT_START;
         step_ff <= '0;
      end else if (cmd.root_step) begin
         if (rem_ff >= trial) begin
            rem_ff  <= rem_ff - trial;
            root_ff <= (root_ff >> 1) + REM_W'(bit_ff);
         end else begin
            root_ff <= root_ff >> 1;
         end
         bit_ff  <= bit_ff >> 2;
         step_ff <= step_ff + STEP_W'(1);
      end
   end

   // result word register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_mag_ff  <= sat_ff ? MAG_LIMIT : root_ff[MAG_W-1:0];
         rsp_row_ff  <= res_row_ff;
         rsp_col_ff  <= res_col_ff;
         rsp_last_ff <= res_last_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_magnitude  = rsp_mag_ff;
   assign rsp_center_row = rsp_row_ff;
   assign rsp_center_col = rsp_col_ff;
   assign rsp_frame_last = rsp_last_ff;

   // a register write restarts the frame
   a_cfg_restart: assert property (@(posedge clock) disable iff (reset)
      csr_we && (csr_index == REG_IMAGE_WIDTH || csr_index == REG_IMAGE_HEIGHT)
      |=> col_ff == '0 && row_ff == '0)
      else $error("frame not restarted after register write");

   // column stays inside the clamped row
   a_col_range: assert property (@(posedge clock) disable iff (reset)
      DIM_W'(col_ff) < w_eff)
      else $error("column counter beyond frame width");

   // never overwrite a waiting result word
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rsp_valid_ff || rsp_ready))
      else $error("result word overwritten while stalled");

   // unsaturated root fits the magnitude
   a_root_range: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out && !sat_ff |-> root_ff < REM_W'(256))
      else $error("square root out of range");

endmodule
